FILE: hdl/spq_pkg.sv
`default_nettype none

package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int LEVELS   = 5;

    localparam int PRIO_W = 3;
    localparam int ID_W   = 16;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    // Saturation ceiling for a requested priority; the field holds 3 bits.
    localparam int PRIO_MAX_INT = (LEVELS - 1 > 7) ? 7 : (LEVELS - 1);
    localparam logic [PRIO_W-1:0] PRIO_MAX = PRIO_W'(PRIO_MAX_INT);

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   ident;
    } t_slot;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic              enq;
        logic              deq;
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   ident;
    } t_cmd;

endpackage

`default_nettype wire

FILE: hdl/stable_priority_queue.sv
`default_nettype none

// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_mode, i_priority_req, i_ident
// result    out        o_valid / i_stall  o_status, o_out_priority, o_out_ident, o_occupancy
//
// A row of CAPACITY cells compares and shifts in parallel, so a new item
// can be taken in every cycle unless the input channel is stalled.
// The result appears in an output register the cycle after acceptance.
// Reset (synchronous, active low) clears the entry count and output valid;
// slot contents are left as they are and only occupied slots are observed.
// A stalled result holds the output register and stalls the input channel.

module stable_priority_queue
    import spq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic              i_mode,
    input  wire logic [PRIO_W-1:0] i_priority_req,
    input  wire logic [ID_W-1:0]   i_ident,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [STAT_W-1:0]      o_status,
    output logic [PRIO_W-1:0]      o_out_priority,
    output logic [ID_W-1:0]        o_out_ident,
    output logic [OCC_W-1:0]       o_occupancy
);

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_valid;
    logic [STAT_W-1:0] r_status;
    logic [STAT_W-1:0] n_status;
    logic [PRIO_W-1:0] r_out_prio;
    logic [PRIO_W-1:0] n_out_prio;
    logic [ID_W-1:0]   r_out_ident;
    logic [ID_W-1:0]   n_out_ident;

    logic        accept;
    logic        is_full;
    logic        no_entries;
    logic [PRIO_W-1:0] prio_sat;
    t_cmd        cmd;
    t_slot       slots [CAPACITY];
    logic        ins   [CAPACITY];

    // Hold the input while a finished result is still waiting downstream.
    assign o_stall = r_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    assign is_full    = (r_count == CAP_CNT);
    assign no_entries = (r_count == '0);

    // Clamp an out-of-range urgency to the least urgent level.
    assign prio_sat = (i_priority_req > PRIO_MAX) ? PRIO_MAX : i_priority_req;

    // Drop the command on a full enqueue or an empty dequeue: state stays put.
    always_comb begin
        cmd.enq   = accept && (i_mode == MODE_ENQ) && !is_full;
        cmd.deq   = accept && (i_mode == MODE_DEQ) && !no_entries;
        cmd.prio  = prio_sat;
        cmd.ident = i_ident;
    end

    // The chain of cells: cell 0 is the head; data moves one cell per command.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic  ins_prev;
        t_slot left;
        t_slot right;

        if (g == 0) begin : g_head
            assign ins_prev = 1'b0;
            assign left     = slots[g];
        end else begin : g_body
            assign ins_prev = ins[g-1];
            assign left     = slots[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right = slots[g];
        end else begin : g_inner
            assign right = slots[g+1];
        end

        spq_cell u_cell (
            .i_clk      (i_clk),
            .i_cmd      (cmd),
            .i_occupied (r_count > CNT_W'(g)),
            .i_ins_prev (ins_prev),
            .i_left     (left),
            .i_right    (right),
            .o_ins      (ins[g]),
            .o_slot     (slots[g])
        );
    end

    always_comb begin
        n_count     = r_count;
        n_status    = ST_DONE;
        n_out_prio  = '0;
        n_out_ident = '0;
        if (i_mode == MODE_ENQ) begin
            if (is_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (no_entries) begin
                n_status = ST_EMPTY;
            end else begin
                n_count     = r_count - 1'b1;
                n_out_prio  = slots[0].prio;
                n_out_ident = slots[0].ident;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result payload: advance on every accepted transaction.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= n_status;
            r_out_prio  <= n_out_prio;
            r_out_ident <= n_out_ident;
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_out_priority = r_out_prio;
    assign o_out_ident    = r_out_ident;
    assign o_occupancy    = OCC_W'(r_count);

endmodule

`default_nettype wire

FILE: hdl/spq_cell.sv
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic  i_clk,
    input  t_cmd       i_cmd,
    input  wire logic  i_occupied,
    input  wire logic  i_ins_prev,
    input  t_slot      i_left,
    input  t_slot      i_right,
    output logic       o_ins,
    output t_slot      o_slot
);

    t_slot r_slot;
    t_slot n_slot;

    // Insertion point lies at or before this cell: free, or strictly less urgent.
    assign o_ins = !i_occupied || (r_slot.prio > i_cmd.prio);

    always_comb begin
        n_slot = r_slot;
        if (i_cmd.enq) begin
            if (o_ins && !i_ins_prev) begin
                n_slot.prio  = i_cmd.prio;
                n_slot.ident = i_cmd.ident;
            end else if (o_ins) begin
                n_slot = i_left;
            end
        end else if (i_cmd.deq) begin
            n_slot = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_slot = r_slot;

endmodule

`default_nettype wire

FILE: hdl/spq_checker.sv
`default_nettype none

module spq_checker
    import spq_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              o_stall,
    input wire logic              i_mode,
    input wire logic [PRIO_W-1:0] i_priority_req,
    input wire logic [ID_W-1:0]   i_ident,
    input wire logic              o_valid,
    input wire logic              i_stall,
    input wire logic [STAT_W-1:0] o_status,
    input wire logic [PRIO_W-1:0] o_out_priority,
    input wire logic [ID_W-1:0]   o_out_ident,
    input wire logic [OCC_W-1:0]  o_occupancy
);

    // Hold a stalled input transaction unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_mode) && $stable(i_priority_req)
            && $stable(i_ident))
        else $error("stalled input changed");

    // Hold a stalled result unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_out_ident)
            && $stable(o_out_priority) && $stable(o_occupancy))
        else $error("stalled result changed");

    // An empty report carries no entry and an empty queue.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_EMPTY) |->
            (o_occupancy == '0) && (o_out_ident == '0) && (o_out_priority == '0))
        else $error("empty report inconsistent");

    // A full report only comes from a queue at capacity.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL) |-> (o_occupancy == OCC_W'(CAPACITY)))
        else $error("full report below capacity");

    // A dequeued entry never carries a priority above the clamp.
    a_prio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_DONE) |-> (o_out_priority <= PRIO_MAX))
        else $error("priority above ceiling");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (.*);

`default_nettype wire
